FILE: hw/rtl/rbfpd_pkg.sv
// Package for the receive byte FIFO with peak level and drop counter.
// Holds operation codes, field widths and default sizes; no dependencies.
package rbfpd_pkg;

  localparam int DEPTH_DEFAULT = 128;

  localparam int OP_W    = 2;
  localparam int BYTE_W  = 8;
  localparam int LEVEL_W = 8;
  localparam int DROP_W  = 16;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_STAT = 2'd2;

endpackage

FILE: hw/rtl/rx_byte_fifo_with_peak_and_drops.sv
// Top level of the receive byte FIFO with peak fill level and drop counter.
// Depends on rbfpd_pkg and instantiates rbfpd_ram for the byte storage.
//
//   channel   handshake            fields
//   command   start, busy          op, data_in
//   result    done (one cycle)     data_out, data_valid, dropped,
//                                  fill_level, peak_level, drop_total
//
// Push, statistics, unused codes and a pop when empty: the result strobes in
// the cycle after the transfer. A pop that returns a byte waits in the read
// state for the registered read port of the storage RAM; busy is high for
// the read cycle. Reset clears pointers, level, peak and drop count; the RAM
// is not cleared. The receiver cannot stall, so results never wait.
module rx_byte_fifo_with_peak_and_drops
  import rbfpd_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    op,
  input  logic [BYTE_W-1:0]  data_in,
  output logic               done,
  output logic [BYTE_W-1:0]  data_out,
  output logic               data_valid,
  output logic               dropped,
  output logic [LEVEL_W-1:0] fill_level,
  output logic [LEVEL_W-1:0] peak_level,
  output logic [DROP_W-1:0]  drop_total
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [LEVEL_W-1:0] DEPTH_LVL = LEVEL_W'(DEPTH);
  localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(DEPTH - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic               state;
  logic [IDX_W-1:0]   write_index;
  logic [IDX_W-1:0]   read_index;
  logic [LEVEL_W-1:0] count;
  logic [LEVEL_W-1:0] peak;
  logic [DROP_W-1:0]  drop_count;

  logic               accept;
  logic               push_ok;
  logic               push_drop;
  logic               pop_ok;
  logic [LEVEL_W-1:0] count_next;
  logic [BYTE_W-1:0]  rdata;

  assign busy      = (state == ST_READ);
  assign accept    = start && !busy;
  assign push_ok   = accept && (op == OP_PUSH) && (count < DEPTH_LVL);
  assign push_drop = accept && (op == OP_PUSH) && (count >= DEPTH_LVL);
  assign pop_ok    = accept && (op == OP_POP) && (count != '0);

  always_comb begin
    count_next = count;
    if (push_ok) begin
      count_next = count + LEVEL_W'(1);
    end else if (pop_ok) begin
      count_next = count - LEVEL_W'(1);
    end
  end

  rbfpd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (push_ok),
    .waddr (write_index),
    .wdata (data_in),
    .re    (pop_ok),
    .raddr (read_index),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      write_index <= '0;
      read_index  <= '0;
      count       <= '0;
      peak        <= '0;
      drop_count  <= '0;
      done        <= 1'b0;
    end else begin
      done  <= 1'b0;
      count <= count_next;
      if (push_ok) begin
        write_index <= (write_index == LAST_IDX) ? '0 : write_index + IDX_W'(1);
        if (count_next > peak) begin
          peak <= count_next;
        end
      end
      if (push_drop) begin
        drop_count <= drop_count + DROP_W'(1);
      end
      if (pop_ok) begin
        read_index <= (read_index == LAST_IDX) ? '0 : read_index + IDX_W'(1);
      end
      if (accept && (op == OP_STAT)) begin
        peak       <= '0;
        drop_count <= '0;
      end
      case (state)
        ST_IDLE: begin
          if (pop_ok) begin
            state <= ST_READ;
          end else if (accept) begin
            done <= 1'b1;
          end
        end
        ST_READ: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      data_out   <= rdata;
      data_valid <= 1'b1;
      dropped    <= 1'b0;
      fill_level <= count;
      peak_level <= peak;
      drop_total <= drop_count;
    end else if (accept) begin
      data_out   <= '0;
      data_valid <= 1'b0;
      dropped    <= push_drop;
      fill_level <= count_next;
      peak_level <= (push_ok && (count_next > peak)) ? count_next : peak;
      drop_total <= push_drop ? drop_count + DROP_W'(1) : drop_count;
    end
  end

endmodule

FILE: hw/rtl/rbfpd_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; used by the receive byte FIFO for its byte storage.
module rbfpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/rbfpd_checker.sv
// Port-level checker for the receive byte FIFO, bound to the top level.
// Depends on rbfpd_pkg for operation codes and field widths.
module rbfpd_checker
  import rbfpd_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [OP_W-1:0]    op,
  input logic               done,
  input logic [BYTE_W-1:0]  data_out,
  input logic               data_valid,
  input logic               dropped,
  input logic [LEVEL_W-1:0] fill_level
);

  // A transfer other than a pop yields its result in the next cycle.
  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op != OP_POP)) |=> (done && !busy))
    else $error("non-pop transfer gave no result in the next cycle");

  // The read cycle of a pop is always followed by its result.
  a_read_then_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && data_valid && !busy))
    else $error("pop read cycle not followed by a valid result");

  a_empty_pop_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !data_valid) |-> (data_out == '0))
    else $error("data_out not zero on a result without data");

  a_drop_when_full: assert property (@(posedge clk) disable iff (rst)
    (done && dropped) |-> (fill_level == LEVEL_W'(DEPTH) && !data_valid))
    else $error("drop reported while the FIFO was not full");

endmodule

bind rx_byte_fifo_with_peak_and_drops rbfpd_checker #(
  .DEPTH (DEPTH)
) u_rbfpd_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .op         (op),
  .done       (done),
  .data_out   (data_out),
  .data_valid (data_valid),
  .dropped    (dropped),
  .fill_level (fill_level)
);

FILE: tb/tb_rx_byte_fifo_with_peak_and_drops.sv
// Self-checking testbench for the receive byte FIFO with peak level and drop counter.
// A mirror class tracks the FIFO contents and statistics and checks every result strobe.
// Depends on rbfpd_pkg and rx_byte_fifo_with_peak_and_drops.
module tb_rx_byte_fifo_with_peak_and_drops;
  import rbfpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [BYTE_W-1:0]  data_out;
    logic               data_valid;
    logic               dropped;
    logic [LEVEL_W-1:0] fill_level;
    logic [LEVEL_W-1:0] peak_level;
    logic [DROP_W-1:0]  drop_total;
  } fifo_reply_t;

  class rx_fifo_mirror;
    logic [BYTE_W-1:0]  bytes_held[DEPTH];
    int                 wr_pos;
    int                 rd_pos;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] peak;
    logic [DROP_W-1:0]  drops;
    fifo_reply_t        replies_due[$];
    int                 mismatches;

    function new();
      wr_pos = 0;
      rd_pos = 0;
      level = '0;
      peak = '0;
      drops = '0;
      mismatches = 0;
    endfunction

    function void note_command(logic [OP_W-1:0] cmd, logic [BYTE_W-1:0] rx_byte);
      fifo_reply_t r;
      r = '0;
      case (cmd)
        OP_PUSH: begin
          if (level < DEPTH) begin
            bytes_held[wr_pos] = rx_byte;
            wr_pos = (wr_pos + 1 >= DEPTH) ? 0 : wr_pos + 1;
            level = level + 1'b1;
            if (level > peak) peak = level;
          end else begin
            drops = drops + 1'b1;
            r.dropped = 1'b1;
          end
        end
        OP_POP: begin
          if (level != 0) begin
            r.data_out = bytes_held[rd_pos];
            r.data_valid = 1'b1;
            rd_pos = (rd_pos + 1 >= DEPTH) ? 0 : rd_pos + 1;
            level = level - 1'b1;
          end
        end
        default: begin
        end
      endcase
      r.fill_level = level;
      r.peak_level = peak;
      r.drop_total = drops;
      if (cmd == OP_STAT) begin
        peak = '0;
        drops = '0;
      end
      replies_due.push_back(r);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $error("%s expected %0d actual %0d", field, want, got);
      end
    endfunction

    function void check_reply(fifo_reply_t got);
      fifo_reply_t want;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $error("result strobe with no transfer outstanding");
        return;
      end
      want = replies_due.pop_front();
      compare_field("data_out", want.data_out, got.data_out);
      compare_field("data_valid", want.data_valid, got.data_valid);
      compare_field("dropped", want.dropped, got.dropped);
      compare_field("fill_level", want.fill_level, got.fill_level);
      compare_field("peak_level", want.peak_level, got.peak_level);
      compare_field("drop_total", want.drop_total, got.drop_total);
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [OP_W-1:0]    op = OP_PUSH;
  logic [BYTE_W-1:0]  data_in = '0;
  logic               done;
  logic [BYTE_W-1:0]  data_out;
  logic               data_valid;
  logic               dropped;
  logic [LEVEL_W-1:0] fill_level;
  logic [LEVEL_W-1:0] peak_level;
  logic [DROP_W-1:0]  drop_total;

  rx_fifo_mirror mirror;
  int            sender_idle_pct = 0;
  int            stall_cycles = 0;

  rx_byte_fifo_with_peak_and_drops #(.DEPTH(DEPTH)) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .data_in(data_in),
    .done(done),
    .data_out(data_out),
    .data_valid(data_valid),
    .dropped(dropped),
    .fill_level(fill_level),
    .peak_level(peak_level),
    .drop_total(drop_total)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) mirror.check_reply({data_out, data_valid, dropped, fill_level, peak_level,
                                    drop_total});
      if (start && !busy) mirror.note_command(op, data_in);
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_item(input logic [OP_W-1:0] cmd, input logic [BYTE_W-1:0] rx_byte);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    op <= cmd;
    data_in <= rx_byte;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (mirror.replies_due.size() != 0);
  endtask

  task automatic run_traffic(input int n_items);
    int left;
    int seg_len;
    int push_pct;
    int pick;
    logic [OP_W-1:0] cmd;
    left = n_items;
    while (left > 0) begin
      seg_len = $urandom_range(20, 200);
      case ($urandom_range(2))
        0: push_pct = 85;
        1: push_pct = 50;
        default: push_pct = 15;
      endcase
      for (int i = 0; i < seg_len && left > 0; i++) begin
        pick = $urandom_range(99);
        if (pick < 3) cmd = OP_STAT;
        else if (pick < 5) cmd = OP_UNUSED;
        else if ($urandom_range(99) < push_pct) cmd = OP_PUSH;
        else cmd = OP_POP;
        send_item(cmd, 8'($urandom_range(255)));
        left--;
      end
    end
  endtask

  initial begin
    int need;
    mirror = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_item(OP_POP, 8'h00);
    send_item(OP_STAT, 8'hFF);
    send_item(OP_UNUSED, 8'h00);
    send_item(OP_PUSH, 8'h00);
    send_item(OP_PUSH, 8'hFF);
    send_item(OP_PUSH, 8'hA5);
    send_item(OP_PUSH, 8'h5A);
    send_item(OP_UNUSED, 8'hFF);
    send_item(OP_STAT, 8'h00);
    send_item(OP_POP, 8'hFF);
    send_item(OP_POP, 8'h00);
    send_item(OP_PUSH, 8'h3C);
    send_item(OP_STAT, 8'hC3);
    send_item(OP_POP, 8'h00);
    send_item(OP_POP, 8'h00);
    send_item(OP_POP, 8'h00);
    send_item(OP_POP, 8'h00);
    send_item(OP_STAT, 8'h00);
    wait_drained();

    sender_idle_pct = 0;
    run_traffic(270);
    wait_drained();
    sender_idle_pct = 85;
    run_traffic(270);
    wait_drained();
    sender_idle_pct = 7;
    run_traffic(270);
    wait_drained();
    sender_idle_pct = 0;
    run_traffic(270);
    wait_drained();

    // Fill the buffer, push into it while full, then drain it past empty.
    need = DEPTH - int'(mirror.level);
    for (int i = 0; i < need; i++) send_item(OP_PUSH, 8'($urandom_range(255)));
    send_item(OP_STAT, 8'h00);
    for (int i = 0; i < 10; i++) send_item(OP_PUSH, 8'($urandom_range(255)));
    send_item(OP_STAT, 8'h00);
    for (int i = 0; i <= DEPTH; i++) send_item(OP_POP, 8'h00);
    wait_drained();

    repeat (4) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.replies_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
